[rtl/stereo_linear_resampler_assert.svh]
// Assertion macros used by the top-level resampler.
`ifndef STEREO_LINEAR_RESAMPLER_ASSERT_SVH
`define STEREO_LINEAR_RESAMPLER_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SLR_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SLR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/slr_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package slr_pkg;

  localparam int unsigned SAMPLE_W             = 16;
  localparam int unsigned STEP_W               = 16;
  localparam int unsigned STEP_FRAC_BITS       = 14;
  localparam int unsigned PHASE_FRAC_BITS_DEF  = 14;
  localparam int unsigned IN_TDATA_W           = 48;
  localparam int unsigned OUT_TDATA_W          = 32;

  localparam logic [STEP_W-1:0] STEP_MIN = 16'd8192;
  localparam logic [STEP_W-1:0] STEP_MAX = 16'd32768;

  typedef struct packed {
    logic load;
    logic last;
  } out_ctl_t;

endpackage

`default_nettype wire

[rtl/stereo_linear_resampler.sv]
// Stereo linear resampler. Each input beat carries a left and a right sample
// and a speed step in Q2.14, clamped to 0.5..2.0 before use. The first beat
// after reset only primes the previous pair. Every later beat yields zero, one
// or two output beats, each the two channels interpolated between the previous
// and the current pair at the running read phase, rounded toward zero and
// saturated to 16 bits; tlast marks the final output beat of an input beat.
// Each output beat passes through the two-stage multiply and add of the channel
// lanes and then the load of the output register, which waits while the output
// register is held by a stalled sink. A new input beat is taken only once the
// last output beat of the current one has been loaded.
`timescale 1ns / 1ps
`default_nettype none

`include "stereo_linear_resampler_assert.svh"

module stereo_linear_resampler #(
  parameter int unsigned PHASE_FRAC_BITS = slr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   s_axis_tvalid_i,
  output logic                                        s_axis_tready_o,
  // in_left [15:0], in_right [31:16], speed_step [47:32]
  input  wire logic [slr_pkg::IN_TDATA_W-1:0]         s_axis_tdata_i,
  output logic                                        m_axis_tvalid_o,
  input  wire logic                                   m_axis_tready_i,
  // out_left [15:0], out_right [31:16]
  output logic      [slr_pkg::OUT_TDATA_W-1:0]        m_axis_tdata_o,
  // last_of_run
  output logic                                        m_axis_tlast_o
);

  localparam int unsigned SW        = slr_pkg::SAMPLE_W;
  localparam int unsigned PhaseW    = PHASE_FRAC_BITS + 2;
  localparam int unsigned WideW     = slr_pkg::STEP_W + PHASE_FRAC_BITS;
  localparam logic [PhaseW-1:0] PhaseOne = {2'b01, {PHASE_FRAC_BITS{1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_OUT
  } state_e;

  state_e                     state_q;
  logic                       have_prev_q;
  logic        [PhaseW-1:0]   phase_q;
  logic        [PhaseW-1:0]   step_q;
  logic signed [SW-1:0]       prev_l_q;
  logic signed [SW-1:0]       prev_r_q;
  logic signed [SW-1:0]       cur_l_q;
  logic signed [SW-1:0]       cur_r_q;

  logic                       s_accept;
  logic signed [SW-1:0]       in_l;
  logic signed [SW-1:0]       in_r;
  logic [slr_pkg::STEP_W-1:0] in_step;
  logic [slr_pkg::STEP_W-1:0] step_clamp;
  logic [WideW-1:0]           step_wide;
  logic [PhaseW-1:0]          step_conv;
  logic [PhaseW-1:0]          phase_next;
  logic                       run_done;
  logic                       out_free;
  slr_pkg::out_ctl_t          out_ctl;
  logic signed [SW-1:0]       lane_l;
  logic signed [SW-1:0]       lane_r;

  assign in_l    = s_axis_tdata_i[SW-1:0];
  assign in_r    = s_axis_tdata_i[2*SW-1:SW];
  assign in_step = s_axis_tdata_i[2*SW+slr_pkg::STEP_W-1:2*SW];

  always_comb begin
    if (in_step < slr_pkg::STEP_MIN) begin
      step_clamp = slr_pkg::STEP_MIN;
    end else if (in_step > slr_pkg::STEP_MAX) begin
      step_clamp = slr_pkg::STEP_MAX;
    end else begin
      step_clamp = in_step;
    end
  end

  assign step_wide = {step_clamp, {PHASE_FRAC_BITS{1'b0}}};
  assign step_conv = step_wide[WideW-1:slr_pkg::STEP_FRAC_BITS];

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;

  assign phase_next = phase_q + step_q;
  assign run_done   = (phase_next >= PhaseOne);

  always_comb begin
    out_ctl.load = (state_q == S_OUT) && out_free;
    out_ctl.last = run_done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      have_prev_q <= 1'b0;
      phase_q     <= '0;
      step_q      <= '0;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      cur_l_q     <= '0;
      cur_r_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (s_accept) begin
            if (!have_prev_q) begin
              have_prev_q <= 1'b1;
              prev_l_q    <= in_l;
              prev_r_q    <= in_r;
            end else if (phase_q >= PhaseOne) begin
              phase_q  <= phase_q - PhaseOne;
              prev_l_q <= in_l;
              prev_r_q <= in_r;
            end else begin
              cur_l_q <= in_l;
              cur_r_q <= in_r;
              step_q  <= step_conv;
              state_q <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state_q <= S_ADD;
        end
        S_ADD: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            if (run_done) begin
              phase_q  <= phase_next - PhaseOne;
              prev_l_q <= cur_l_q;
              prev_r_q <= cur_r_q;
              state_q  <= S_IDLE;
            end else begin
              phase_q <= phase_next;
              state_q <= S_MUL;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  slr_lane #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_lane_l (
    .clk_i   (clk_i),
    .prev_i  (prev_l_q),
    .cur_i   (cur_l_q),
    .frac_i  (phase_q[PHASE_FRAC_BITS-1:0]),
    .sample_o(lane_l)
  );

  slr_lane #(
    .PHASE_FRAC_BITS(PHASE_FRAC_BITS)
  ) u_lane_r (
    .clk_i   (clk_i),
    .prev_i  (prev_r_q),
    .cur_i   (cur_r_q),
    .frac_i  (phase_q[PHASE_FRAC_BITS-1:0]),
    .sample_o(lane_r)
  );

  slr_out u_out (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctl_i          (out_ctl),
    .left_i         (lane_l),
    .right_i        (lane_r),
    .free_o         (out_free),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  `SLR_ASSERT_NOW(a_load_below_one, clk_i, rst_ni, out_ctl.load, phase_q < PhaseOne, "output loaded with phase at or above one")
  `SLR_ASSERT_NEXT(a_start_run, clk_i, rst_ni, s_accept && have_prev_q && (phase_q < PhaseOne), state_q == S_MUL, "run did not start after an accepted beat")
  `SLR_ASSERT_NOW(a_run_has_prev, clk_i, rst_ni, state_q != S_IDLE, have_prev_q, "interpolation running without a previous pair")

endmodule

`default_nettype wire

[rtl/slr_lane.sv]
`timescale 1ns / 1ps
`default_nettype none

module slr_lane #(
  parameter int unsigned PHASE_FRAC_BITS = slr_pkg::PHASE_FRAC_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0] prev_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0] cur_i,
  input  wire logic        [PHASE_FRAC_BITS-1:0]   frac_i,
  output logic      signed [slr_pkg::SAMPLE_W-1:0] sample_o
);

  localparam int unsigned DiffW = slr_pkg::SAMPLE_W + 1;
  localparam int unsigned ProdW = DiffW + PHASE_FRAC_BITS + 1;
  localparam int unsigned NumW  = ProdW + 1;
  localparam int unsigned QuoW  = NumW - PHASE_FRAC_BITS;

  localparam logic signed [QuoW-1:0] QuoMax =
    QuoW'((1 << (slr_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [QuoW-1:0] QuoMin = ~QuoMax;

  logic signed [DiffW-1:0]             diff;
  logic signed [ProdW-1:0]             prod_d;
  logic signed [ProdW-1:0]             prod_q;
  logic signed [slr_pkg::SAMPLE_W-1:0] base_q;
  logic signed [NumW-1:0]              num;
  logic signed [QuoW-1:0]              quo;
  logic signed [QuoW-1:0]              quo_rnd;
  logic                                rnd;
  logic signed [slr_pkg::SAMPLE_W-1:0] sample_d;
  logic signed [slr_pkg::SAMPLE_W-1:0] sample_q;

  assign diff   = $signed({cur_i[slr_pkg::SAMPLE_W-1], cur_i})
                - $signed({prev_i[slr_pkg::SAMPLE_W-1], prev_i});
  assign prod_d = diff * $signed({1'b0, frac_i});

  // Division by one phase unit rounds toward zero, so a negative sum with a
  // nonzero fraction moves up by one.
  assign num = $signed({prod_q[ProdW-1], prod_q})
             + $signed({{(NumW - slr_pkg::SAMPLE_W - PHASE_FRAC_BITS){base_q[slr_pkg::SAMPLE_W-1]}},
                        base_q, {PHASE_FRAC_BITS{1'b0}}});
  assign quo     = num[NumW-1:PHASE_FRAC_BITS];
  assign rnd     = num[NumW-1] & (|num[PHASE_FRAC_BITS-1:0]);
  assign quo_rnd = quo + $signed({{(QuoW-1){1'b0}}, rnd});

  always_comb begin
    if (quo_rnd > QuoMax) begin
      sample_d = QuoMax[slr_pkg::SAMPLE_W-1:0];
    end else if (quo_rnd < QuoMin) begin
      sample_d = QuoMin[slr_pkg::SAMPLE_W-1:0];
    end else begin
      sample_d = quo_rnd[slr_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q   <= prod_d;
    base_q   <= prev_i;
    sample_q <= sample_d;
  end

  assign sample_o = sample_q;

endmodule

`default_nettype wire

[rtl/slr_out.sv]
`timescale 1ns / 1ps
`default_nettype none

module slr_out (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire slr_pkg::out_ctl_t                     ctl_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]   left_i,
  input  wire logic signed [slr_pkg::SAMPLE_W-1:0]   right_i,
  output logic                                       free_o,
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // out_left [15:0], out_right [31:16]
  output logic             [slr_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // last_of_run
  output logic                                       m_axis_tlast_o
);

  logic                              valid_d;
  logic                              valid_q;
  logic [slr_pkg::OUT_TDATA_W-1:0]   data_q;
  logic                              last_q;

  assign free_o  = !valid_q || m_axis_tready_i;
  assign valid_d = ctl_i.load || (valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q <= {right_i, left_i};
      last_q <= ctl_i.last;
    end
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

`default_nettype wire
